/* rtl/erm_pkg.sv */
// Shared constants and arithmetic helpers for the Euler rotation matrix block.
// Used by erm_sincos and euler_rotation_matrix; depends on nothing else.
`default_nettype none
package erm_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int OUT_FRAC_BITS_DEF   = 14;
    localparam int ANGLE_W             = 16;
    localparam int OUT_W               = 16;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] HALF_Q30 = 64'd536870912;
    localparam logic [31:0] ONE_Q30  = 32'd1073741824;

    // Register stages inside one sine/cosine unit.
    localparam int SC_LAT = 31;

    // Q2.30 product, rounded half away from zero.
    function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        logic        [63:0] mag;
        logic        [31:0] r;
        p   = a * b;
        mag = p[63] ? 64'(-p) : 64'(p);
        r   = 32'((mag + HALF_Q30) >> 30);
        return p[63] ? -$signed(r) : $signed(r);
    endfunction

endpackage
`default_nettype wire

/* rtl/erm_sincos.sv */
// Pipelined sine and cosine of one angle in degrees, Q2.30 results.
// Angle reduction, radian scaling and a Taylor series; uses erm_pkg.
`default_nettype none
module erm_sincos #(
    parameter int ANGLE_FRAC_BITS = erm_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [erm_pkg::ANGLE_W-1:0]  angle,
    output logic signed [31:0]                       sin_o,
    output logic signed [31:0]                       cos_o
);
    import erm_pkg::*;

    localparam int FULL  = 360 << ANGLE_FRAC_BITS;
    localparam int QUART = 90 << ANGLE_FRAC_BITS;
    localparam int OFF   = FULL * ((32768 + FULL - 1) / FULL);
    localparam int UW    = 22;
    localparam int MFW   = 14;
    localparam logic [MFW-1:0] MF = MFW'((64'd1 << UW) / 64'(FULL));
    localparam int RW    = 21;
    localparam logic [63:0] HALF_D = 64'(90) << ANGLE_FRAC_BITS;
    localparam logic [12:0] M1 = 13'((64'd1 << 20) / 64'd180);
    localparam logic [20:0] M2 = 21'((64'd1 << 28) / 64'd180);
    localparam int NSTEP = 7;
    localparam int NSER  = 3 * NSTEP + 1;

    typedef struct packed {
        logic [31:0]        x2;
        logic [31:0]        t_s;
        logic [31:0]        t_c;
        logic [63:0]        p_s;
        logic [63:0]        p_c;
        logic signed [34:0] sum_s;
        logic signed [34:0] sum_c;
        logic [1:0]         qd;
    } ser_t;

    logic signed [UW:0]      ue;
    logic [UW-1:0]           u1_reg;
    logic [UW+MFW-1:0]       pm1_reg;
    logic [UW:0]             r0;
    logic [RW-1:0]           r2_reg;
    logic [8:0]              rs;
    logic [1:0]              qd3;
    logic [1:0]              qd_reg [3:8];
    logic [18:0]             rem3_reg;
    logic [63:0]             yw;
    logic [38:0]             y4_reg;
    logic [31:0]             p5_reg;
    logic [18:0]             yh5_reg;
    logic [19:0]             yl5_reg;
    logic [11:0]             q1;
    logic [19:0]             r1;
    logic [11:0]             q1_6_reg;
    logic [27:0]             z6_reg;
    logic [11:0]             q1_7_reg;
    logic [27:0]             z7_reg;
    logic [48:0]             p7_reg;
    logic [20:0]             q2;
    logic [27:0]             r2;
    logic [31:0]             theta8_reg;
    logic [63:0]             sq;
    ser_t                    ser_reg [0:NSER-1];
    logic [31:0]             s_cl;
    logic [31:0]             c_cl;

    assign ue = {{(UW + 1 - ANGLE_W){angle[ANGLE_W-1]}}, angle} + (UW + 1)'(OFF);
    assign r0 = {1'b0, u1_reg} - (UW + 1)'(pm1_reg[UW+MFW-1:UW] * (UW + 1)'(FULL));
    assign rs = 9'(r2_reg >> ANGLE_FRAC_BITS);
    assign qd3 = (rs >= 9'd270) ? 2'd3 : (rs >= 9'd180) ? 2'd2 : (rs >= 9'd90) ? 2'd1 : 2'd0;
    assign yw = 64'(rem3_reg) * PI_Q30 + HALF_D;
    assign q1 = p5_reg[31:20];
    assign r1 = {1'b0, yh5_reg} - 20'(q1 * 20'd180);
    assign q2 = p7_reg[48:28];
    assign r2 = z7_reg - 28'(q2 * 28'd180);
    assign sq = 64'(theta8_reg) * 64'(theta8_reg) + HALF_Q30;

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg   <= ue[UW-1:0];
            pm1_reg  <= ue[UW-1:0] * MF;
            r2_reg   <= (r0 >= (UW + 1)'(FULL)) ? RW'(r0 - (UW + 1)'(FULL)) : RW'(r0);
            qd_reg[3] <= qd3;
            rem3_reg <= 19'(RW'(r2_reg) - RW'(qd3 * RW'(QUART)));
            qd_reg[4] <= qd_reg[3];
            y4_reg   <= 39'(yw >> ANGLE_FRAC_BITS);
            qd_reg[5] <= qd_reg[4];
            p5_reg   <= 32'(y4_reg[38:20]) * 32'(M1);
            yh5_reg  <= y4_reg[38:20];
            yl5_reg  <= y4_reg[19:0];
            qd_reg[6] <= qd_reg[5];
            q1_6_reg <= (r1 >= 20'd180) ? q1 + 12'd1 : q1;
            z6_reg   <= {(r1 >= 20'd180) ? 8'(r1 - 20'd180) : r1[7:0], yl5_reg};
            qd_reg[7] <= qd_reg[6];
            q1_7_reg <= q1_6_reg;
            z7_reg   <= z6_reg;
            p7_reg   <= z6_reg * M2;
            qd_reg[8] <= qd_reg[7];
            theta8_reg <= {q1_7_reg, 20'd0} + 32'((r2 >= 28'd180) ? q2 + 21'd1 : q2);
            ser_reg[0].x2    <= 32'(sq >> 30);
            ser_reg[0].t_s   <= theta8_reg;
            ser_reg[0].t_c   <= ONE_Q30;
            ser_reg[0].p_s   <= '0;
            ser_reg[0].p_c   <= '0;
            ser_reg[0].sum_s <= $signed({3'b000, theta8_reg});
            ser_reg[0].sum_c <= $signed({3'b000, ONE_Q30});
            ser_reg[0].qd    <= qd_reg[8];
        end
    end

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        localparam int K  = j + 1;
        localparam int NS = 2 * K * (2 * K + 1);
        localparam int NC = (2 * K - 1) * (2 * K);
        localparam logic [63:0] MS = 64'h1_0000_0000 / 64'(NS);
        localparam logic [63:0] MC = 64'h1_0000_0000 / 64'(NC);
        localparam bit HAS_SIN = (j < 6);
        localparam bit NEG = ((K % 2) == 1);

        ser_t a_next;
        ser_t b_next;
        ser_t c_next;
        ser_t a_in;
        ser_t b_in;
        ser_t c_in;
        logic [31:0] qs;
        logic [31:0] qc;
        logic [31:0] rsr;
        logic [31:0] rcr;
        logic [31:0] ts;
        logic [31:0] tc;

        assign a_in = ser_reg[3*j];
        assign b_in = ser_reg[3*j+1];
        assign c_in = ser_reg[3*j+2];

        always_comb begin
            a_next = a_in;
            a_next.t_c = 32'((64'(a_in.t_c) * 64'(a_in.x2) + HALF_Q30) >> 30);
            if (HAS_SIN) begin
                a_next.t_s = 32'((64'(a_in.t_s) * 64'(a_in.x2) + HALF_Q30) >> 30);
            end
        end

        always_comb begin
            b_next = b_in;
            b_next.t_c = b_in.t_c + 32'(NC / 2);
            b_next.p_c = 64'(b_in.t_c + 32'(NC / 2)) * MC;
            if (HAS_SIN) begin
                b_next.t_s = b_in.t_s + 32'(NS / 2);
                b_next.p_s = 64'(b_in.t_s + 32'(NS / 2)) * MS;
            end
        end

        always_comb begin
            qs  = c_in.p_s[63:32];
            qc  = c_in.p_c[63:32];
            rsr = c_in.t_s - 32'(qs * 32'(NS));
            rcr = c_in.t_c - 32'(qc * 32'(NC));
            ts  = (rsr >= 32'(NS)) ? qs + 32'd1 : qs;
            tc  = (rcr >= 32'(NC)) ? qc + 32'd1 : qc;
            c_next = c_in;
            c_next.t_c = tc;
            c_next.sum_c = NEG ? c_in.sum_c - $signed({3'b000, tc})
                               : c_in.sum_c + $signed({3'b000, tc});
            if (HAS_SIN) begin
                c_next.t_s = ts;
                c_next.sum_s = NEG ? c_in.sum_s - $signed({3'b000, ts})
                                   : c_in.sum_s + $signed({3'b000, ts});
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ser_reg[3*j+1] <= a_next;
                ser_reg[3*j+2] <= b_next;
                ser_reg[3*j+3] <= c_next;
            end
        end
    end

    always_comb begin
        if (ser_reg[NSER-1].sum_s < 0) begin
            s_cl = '0;
        end else if (ser_reg[NSER-1].sum_s > $signed({3'b000, ONE_Q30})) begin
            s_cl = ONE_Q30;
        end else begin
            s_cl = 32'(ser_reg[NSER-1].sum_s);
        end
        if (ser_reg[NSER-1].sum_c < 0) begin
            c_cl = '0;
        end else if (ser_reg[NSER-1].sum_c > $signed({3'b000, ONE_Q30})) begin
            c_cl = ONE_Q30;
        end else begin
            c_cl = 32'(ser_reg[NSER-1].sum_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            case (ser_reg[NSER-1].qd)
                2'd0: begin
                    sin_o <= $signed(s_cl);
                    cos_o <= $signed(c_cl);
                end
                2'd1: begin
                    sin_o <= $signed(c_cl);
                    cos_o <= -$signed(s_cl);
                end
                2'd2: begin
                    sin_o <= -$signed(s_cl);
                    cos_o <= -$signed(c_cl);
                end
                default: begin
                    sin_o <= -$signed(c_cl);
                    cos_o <= $signed(s_cl);
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/euler_rotation_matrix.sv */
// Throughput: one request per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall at the output freezes it.
// Reset clears only the valid bits of the pipeline; the data path needs none.
// Rotation matrix: three erm_sincos units, then product, sum and round stages.
// Depends on erm_pkg and erm_sincos.
`default_nettype none
module euler_rotation_matrix #(
    parameter int ANGLE_FRAC_BITS = erm_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = erm_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [erm_pkg::ANGLE_W-1:0] s_angle_x,
    input  wire logic signed [erm_pkg::ANGLE_W-1:0] s_angle_y,
    input  wire logic signed [erm_pkg::ANGLE_W-1:0] s_angle_z,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [erm_pkg::OUT_W-1:0]        m_m00,
    output logic signed [erm_pkg::OUT_W-1:0]        m_m01,
    output logic signed [erm_pkg::OUT_W-1:0]        m_m02,
    output logic signed [erm_pkg::OUT_W-1:0]        m_m10,
    output logic signed [erm_pkg::OUT_W-1:0]        m_m11,
    output logic signed [erm_pkg::OUT_W-1:0]        m_m12,
    output logic signed [erm_pkg::OUT_W-1:0]        m_m20,
    output logic signed [erm_pkg::OUT_W-1:0]        m_m21,
    output logic signed [erm_pkg::OUT_W-1:0]        m_m22
);
    import erm_pkg::*;

    localparam int LAT   = SC_LAT + 3;
    localparam int SHIFT = 30 - OUT_FRAC_BITS;
    localparam logic [33:0] RND = (SHIFT > 0) ? (34'd1 << ((SHIFT > 0) ? SHIFT - 1 : 0)) : 34'd0;
    localparam logic [33:0] ONE = 34'd1 << OUT_FRAC_BITS;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic signed [31:0] sx, cx, sy, cy, sz, cz;
    logic signed [31:0] cycz_reg, cysz_reg, sxsy_reg, cxsz_reg, cxcz_reg;
    logic signed [31:0] sxcy_reg, sxsz_reg, cxsy_reg, sxcz_reg, cxcy_reg;
    logic signed [31:0] sy_reg, sz_reg, cz_reg;
    logic signed [33:0] e_reg [0:8];

    function automatic logic [OUT_W-1:0] to_out(input logic signed [33:0] v);
        logic [33:0] mag;
        logic [33:0] r;
        mag = v[33] ? 34'(-v) : 34'(v);
        mag = (mag + RND) >> SHIFT;
        if (mag > ONE) begin
            mag = ONE;
        end
        r = v[33] ? 34'(-mag) : mag;
        return r[OUT_W-1:0];
    endfunction

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];
    assign vld_next = en ? {vld_reg[LAT-2:0], s_valid} : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_x (
        .aclk(aclk), .en(en), .angle(s_angle_x), .sin_o(sx), .cos_o(cx)
    );
    erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_y (
        .aclk(aclk), .en(en), .angle(s_angle_y), .sin_o(sy), .cos_o(cy)
    );
    erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_z (
        .aclk(aclk), .en(en), .angle(s_angle_z), .sin_o(sz), .cos_o(cz)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            cycz_reg <= mul30(cy, cz);
            cysz_reg <= mul30(cy, sz);
            sxsy_reg <= mul30(sx, sy);
            cxsz_reg <= mul30(cx, sz);
            cxcz_reg <= mul30(cx, cz);
            sxcy_reg <= mul30(sx, cy);
            sxsz_reg <= mul30(sx, sz);
            cxsy_reg <= mul30(cx, sy);
            sxcz_reg <= mul30(sx, cz);
            cxcy_reg <= mul30(cx, cy);
            sy_reg   <= sy;
            sz_reg   <= sz;
            cz_reg   <= cz;

            e_reg[0] <= 34'(cycz_reg);
            e_reg[1] <= -34'(cysz_reg);
            e_reg[2] <= 34'(sy_reg);
            e_reg[3] <= 34'(mul30(sxsy_reg, cz_reg)) + 34'(cxsz_reg);
            e_reg[4] <= 34'(cxcz_reg) - 34'(mul30(sxsy_reg, sz_reg));
            e_reg[5] <= -34'(sxcy_reg);
            e_reg[6] <= 34'(sxsz_reg) - 34'(mul30(cxsy_reg, cz_reg));
            e_reg[7] <= 34'(mul30(cxsy_reg, sz_reg)) + 34'(sxcz_reg);
            e_reg[8] <= 34'(cxcy_reg);

            m_m00 <= to_out(e_reg[0]);
            m_m01 <= to_out(e_reg[1]);
            m_m02 <= to_out(e_reg[2]);
            m_m10 <= to_out(e_reg[3]);
            m_m11 <= to_out(e_reg[4]);
            m_m12 <= to_out(e_reg[5]);
            m_m20 <= to_out(e_reg[6]);
            m_m21 <= to_out(e_reg[7]);
            m_m22 <= to_out(e_reg[8]);
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during an output stall");

    a_m00_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && OUT_FRAC_BITS <= 14) |->
        ($signed(m_m00) <= $signed(17'(ONE)) && $signed(m_m00) >= -$signed(17'(ONE))))
        else $error("m00 outside the unit range");

    a_m22_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && OUT_FRAC_BITS <= 14) |->
        ($signed(m_m22) <= $signed(17'(ONE)) && $signed(m_m22) >= -$signed(17'(ONE))))
        else $error("m22 outside the unit range");

endmodule
`default_nettype wire
